// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs nothing; simulation builds get checks, SYNTHESIS builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RDSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rdsc assertion failed");
`define RDSC_NEVER(lbl, clk, rstn, cond) \
  `RDSC_ASSERT(lbl, clk, rstn, !(cond))
`else
`define RDSC_ASSERT(lbl, clk, rstn, prop)
`define RDSC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: hw/rtl/rdsc_pkg.sv
// Package for the radix digit string converter: constants, types, digit helpers.
// No dependencies.
`timescale 1ns / 1ps
package rdsc_pkg;

  localparam int unsigned MAX_OUT_CHARS = 64;
  localparam int unsigned STORE_DEPTH   = 64;
  localparam int unsigned IDX_W         = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W         = $clog2(STORE_DEPTH + 1);
  localparam int unsigned BASE_W        = 6;
  localparam int unsigned MAG_W         = 63;
  localparam int unsigned DIV_W         = 64;   // dividend, padded to a multiple of 4
  localparam int unsigned DIV_BITS      = 4;    // quotient bits per cycle
  localparam int unsigned DIV_STEPS     = DIV_W / DIV_BITS;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);

  localparam logic [7:0]        CHAR_ZERO  = 8'h30;
  localparam logic [7:0]        CHAR_NINE  = 8'h39;
  localparam logic [7:0]        CHAR_A     = 8'h41;
  localparam logic [7:0]        CHAR_Z     = 8'h5A;
  localparam logic [7:0]        CHAR_MINUS = 8'h2D;
  localparam logic [BASE_W-1:0] DEC_TEN    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [6:0]        DIGIT_BAD  = 7'd64;
  localparam logic [MAG_W-1:0]  MAG_MAX    = {MAG_W{1'b1}};

  localparam logic REG_SRC_BASE = 1'b0;
  localparam logic REG_TGT_BASE = 1'b1;

  typedef struct packed {
    logic acc;        // absorb one input character
    logic div_load;   // load dividend from accumulator
    logic div_step;   // one divider iteration
    logic emit_rd;    // read digit store
    logic emit_ld;    // load output register
    logic emit_next;  // output transfer done
    logic clear;      // back to start of number
  } cmd_t;

  typedef struct packed {
    logic div_last;   // last iteration of the current digit
    logic conv_done;  // no more digits after this one
    logic emit_last;  // current output char is the final one
  } sts_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  function automatic logic [6:0] digit_value(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return 7'(c - CHAR_ZERO);
    if (c >= CHAR_A && c <= CHAR_Z) return 7'(c - CHAR_A) + 7'(DEC_TEN);
    return DIGIT_BAD;
  endfunction

  function automatic logic [7:0] digit_char(input logic [BASE_W-1:0] d);
    if (d >= DEC_TEN) return CHAR_A + 8'(d - DEC_TEN);
    return CHAR_ZERO + 8'(d);
  endfunction

endpackage

// File: hw/rtl/rdsc_if.sv
// Stream interfaces for the converter: input characters and result characters.
// Depends on nothing.
`timescale 1ns / 1ps
interface rdsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_in;
  modport source (output valid, char_in, last_in, input ready);
  modport sink   (input valid, char_in, last_in, output ready);
endinterface

interface rdsc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         char_out;
  logic               last_out;
  logic signed [63:0] signed_value;
  logic               overflow;
  logic               bad_digit;
  modport source (output valid, char_out, last_out, signed_value, overflow, bad_digit,
                  input ready);
  modport sink   (input valid, char_out, last_out, signed_value, overflow, bad_digit,
                  output ready);
endinterface

// File: hw/rtl/rdsc_ctrl.sv
// Controller FSM: sequences accumulate, divide, and emit phases.
// Depends on rdsc_pkg.
`timescale 1ns / 1ps
module rdsc_ctrl import rdsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_INIT, ST_DIV, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.acc       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_load  = (state_q == ST_DIV_INIT);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.emit_rd   = (state_q == ST_EMIT_RD);
    cmd_o.emit_ld   = (state_q == ST_EMIT_LD);
    cmd_o.emit_next = (state_q == ST_EMIT_WAIT) && out_ready_i;
    cmd_o.clear     = cmd_o.emit_next && sts_i.emit_last;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT_WAIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_last_i) state_q <= ST_DIV_INIT;
        end
        ST_DIV_INIT: state_q <= ST_DIV;
        ST_DIV: begin
          if (sts_i.div_last && sts_i.conv_done) state_q <= ST_EMIT_RD;
        end
        ST_EMIT_RD: state_q <= ST_EMIT_LD;
        ST_EMIT_LD: state_q <= ST_EMIT_WAIT;
        ST_EMIT_WAIT: begin
          if (out_ready_i) state_q <= sts_i.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/rdsc_dp.sv
// Datapath: accumulator, radix-16 restoring divider, digit store, output register.
// Depends on rdsc_pkg.
`timescale 1ns / 1ps
module rdsc_dp import rdsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BASE_W-1:0]  src_base_i,
  input  logic [BASE_W-1:0]  tgt_base_i,
  input  logic [7:0]         char_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic [7:0]         char_o,
  output logic               last_o,
  output logic signed [63:0] value_o,
  output logic               overflow_o,
  output logic               bad_digit_o
);

  localparam int unsigned PROD_W = MAG_W + BASE_W + 1;

  logic [MAG_W-1:0]  mag_q;
  logic              neg_q, first_q, ovf_q, err_q;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [BASE_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  nd_q, k_q, total;
  logic [BASE_W-1:0] store_q [STORE_DEPTH];
  logic [BASE_W-1:0] rdata_q;
  logic [IDX_W-1:0]  pos;
  logic              sign;
  logic [BASE_W-1:0] sb, tb;
  logic [6:0]        dval;
  logic [PROD_W-1:0] prod;

  assign sb   = clamp_base(src_base_i);
  assign tb   = clamp_base(tgt_base_i);
  assign dval = digit_value(char_i);
  assign prod = PROD_W'(mag_q) * PROD_W'(sb) + PROD_W'(dval);

  // four restoring steps, remainder stays below the base
  always_comb begin
    logic [BASE_W:0] r7;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      r7    = {rem_d, quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (r7 >= {1'b0, tb}) begin
        r7       = r7 - {1'b0, tb};
        quo_d[0] = 1'b1;
      end
      rem_d = r7[BASE_W-1:0];
    end
  end

  assign sign  = neg_q && (mag_q != '0);
  assign total = ((nd_q + CNT_W'(sign)) > CNT_W'(MAX_OUT_CHARS)) ?
                 CNT_W'(MAX_OUT_CHARS) : (nd_q + CNT_W'(sign));
  assign pos   = IDX_W'(nd_q) - IDX_W'(1) - IDX_W'(k_q) + IDX_W'(sign);

  assign sts_o.div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
  assign sts_o.conv_done = (quo_d == '0) || (nd_q == CNT_W'(STORE_DEPTH - 1));
  assign sts_o.emit_last = (k_q + CNT_W'(1) == total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg_q   <= 1'b0;
      first_q <= 1'b1;
      ovf_q   <= 1'b0;
      err_q   <= 1'b0;
      step_q  <= '0;
      nd_q    <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.acc) begin
        first_q <= 1'b0;
        if (first_q && char_i == CHAR_MINUS) begin
          neg_q <= 1'b1;
        end else if (dval >= 7'(sb)) begin
          err_q <= 1'b1;
        end else if (ovf_q || prod > PROD_W'(MAG_MAX)) begin
          mag_q <= MAG_MAX;
          ovf_q <= 1'b1;
        end else begin
          mag_q <= prod[MAG_W-1:0];
        end
      end
      if (cmd_i.div_load) begin
        step_q <= '0;
        nd_q   <= '0;
        k_q    <= '0;
      end
      if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
        if (sts_o.div_last) nd_q <= nd_q + CNT_W'(1);
      end
      if (cmd_i.emit_next) k_q <= k_q + CNT_W'(1);
      if (cmd_i.clear) begin
        mag_q   <= '0;
        neg_q   <= 1'b0;
        first_q <= 1'b1;
        ovf_q   <= 1'b0;
        err_q   <= 1'b0;
      end
    end
  end

  // divider payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q <= {{(DIV_W-MAG_W){1'b0}}, mag_q};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= sts_o.div_last ? '0 : rem_d;
    end
  end

  // digit store, least significant digit at entry 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && sts_o.div_last) store_q[nd_q[IDX_W-1:0]] <= rem_d;
    if (cmd_i.emit_rd) rdata_q <= store_q[pos];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      char_o      <= (sign && k_q == '0) ? CHAR_MINUS : digit_char(rdata_q);
      last_o      <= sts_o.emit_last;
      value_o     <= neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
      overflow_o  <= ovf_q;
      bad_digit_o <= err_q;
    end
  end

endmodule

// File: hw/rtl/radix_digit_string_converter.sv
// Radix digit string converter. Characters arrive one per transfer on in_i:
// an optional leading '-', then digits '0'-'9','A'-'Z' in source_base (reg 0,
// byte addr 0). Each character is absorbed by a 63x6 multiply-add with
// saturation. On the transfer flagged last_in the magnitude is converted to
// target_base (reg 1, byte addr 4) by a restoring divider that retires 4
// quotient bits per cycle: a load step, then one division per digit. Digits
// go to a 64-entry store, then out most significant first, each char via the
// read, load and wait states. A bad digit sets bad_digit and is skipped;
// overflow saturates at 2^63-1. Zero prints "0", negative zero prints "0"
// unsigned. in_i is ready only while idle. Bases outside 2..36 are clamped.
// The user must write registers only when idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module radix_digit_string_converter import rdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rdsc_in_if.sink     in_i,
  rdsc_out_if.source  out_o
);

  logic [BASE_W-1:0] src_base_q, tgt_base_q;
  cmd_t              cmd;
  sts_t              sts;
  logic              reg_sel;

  // config registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_TGT_BASE) ? 32'(tgt_base_q) : 32'(src_base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q <= DEC_TEN;
      tgt_base_q <= DEC_TEN;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == REG_SRC_BASE) src_base_q <= pwdata[BASE_W-1:0];
      else                         tgt_base_q <= pwdata[BASE_W-1:0];
    end
  end

  rdsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_in),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rdsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_base_i  (src_base_q),
    .tgt_base_i  (tgt_base_q),
    .char_i      (in_i.char_in),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .char_o      (out_o.char_out),
    .last_o      (out_o.last_out),
    .value_o     (out_o.signed_value),
    .overflow_o  (out_o.overflow),
    .bad_digit_o (out_o.bad_digit)
  );

  // one number in flight: input and output sides never active together
  `RDSC_NEVER(a_no_overlap, clk_i, rst_ni, in_i.ready && out_o.valid)
  // final char transfer returns to idle
  `RDSC_ASSERT(a_idle_after_last, clk_i, rst_ni,
    out_o.valid && out_o.ready && out_o.last_out |=> in_i.ready)
  // saturated value is always +/- max magnitude
  `RDSC_ASSERT(a_sat_value, clk_i, rst_ni,
    out_o.valid && out_o.overflow |->
      (out_o.signed_value == 64'sh7FFFFFFFFFFFFFFF ||
       out_o.signed_value == -64'sh7FFFFFFFFFFFFFFF))

endmodule

// File: bench/testbench.sv
// Self-checking bench for radix_digit_string_converter: digit strings in, converted strings out.
// Depends on rdsc_pkg and the rdsc_in_if / rdsc_out_if interfaces from the RTL.
`timescale 1ns / 1ps
module testbench;
  import rdsc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam logic [63:0] SAT_MAG        = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [7:0]         ch;
    logic               last;
    logic signed [63:0] value;
    logic               ovf;
    logic               bad;
  } out_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rdsc_in_if  in_if ();
  rdsc_out_if out_if ();

  radix_digit_string_converter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(in_if.sink), .out_o(out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block's registers and per-number state.
  logic [5:0]  src_reg = 6'd10;
  logic [5:0]  tgt_reg = 6'd10;
  logic [63:0] mag_acc = '0;
  logic        neg_seen = 1'b0;
  logic        at_first = 1'b1;
  logic        sat_seen = 1'b0;
  logic        bad_seen = 1'b0;

  char_item_t pending_chars[$];
  out_char_t  expected_chars[$];
  bit         idle_on = 1'b1;
  int         mismatches = 0;
  int         idle_cycles = 0;

  function automatic logic [5:0] eff_base(input logic [5:0] b);
    return (b < 6'd2) ? 6'd2 : ((b > 6'd36) ? 6'd36 : b);
  endfunction

  function automatic logic [7:0] to_ascii(input logic [5:0] d);
    return (d < 6'd10) ? 8'h30 + 8'(d) : 8'h41 + 8'(d - 6'd10);
  endfunction

  // Absorb one accepted character; on the final one queue the converted string.
  task automatic absorb_char(input char_item_t it);
    logic [63:0] sb, tb, dv, m;
    logic [5:0]  digs[64];
    logic signed [63:0] sval;
    int nd, total;
    bit sign;
    out_char_t r;
    sb = 64'(eff_base(src_reg));
    if (at_first && it.ch == CHAR_MINUS) begin
      neg_seen = 1'b1;
    end else begin
      if (it.ch >= 8'h30 && it.ch <= 8'h39) dv = 64'(it.ch - 8'h30);
      else if (it.ch >= 8'h41 && it.ch <= 8'h5A) dv = 64'(it.ch - 8'h41) + 64'd10;
      else dv = 64'd64;
      if (dv >= sb) begin
        bad_seen = 1'b1;
      end else if (sat_seen || mag_acc > (SAT_MAG - dv) / sb) begin
        mag_acc = SAT_MAG;
        sat_seen = 1'b1;
      end else begin
        mag_acc = mag_acc * sb + dv;
      end
    end
    at_first = 1'b0;
    if (!it.last) return;
    tb = 64'(eff_base(tgt_reg));
    m = mag_acc;
    nd = 0;
    do begin
      digs[nd] = 6'(m % tb);
      nd++;
      m = m / tb;
    end while (m != 0 && nd < 64);
    sign = neg_seen && mag_acc != 0;
    sval = neg_seen ? -$signed(mag_acc) : $signed(mag_acc);
    total = nd + (sign ? 1 : 0);
    if (total > MAX_OUT_CHARS) total = MAX_OUT_CHARS;
    for (int k = 0; k < total; k++) begin
      if (sign && k == 0) r.ch = CHAR_MINUS;
      else r.ch = to_ascii(digs[nd - 1 - (k - (sign ? 1 : 0))]);
      r.last = (k == total - 1);
      r.value = sval;
      r.ovf = sat_seen;
      r.bad = bad_seen;
      expected_chars.push_back(r);
    end
    mag_acc = '0;
    neg_seen = 1'b0;
    at_first = 1'b1;
    sat_seen = 1'b0;
    bad_seen = 1'b0;
  endtask

  // Sender: one transfer per queued character, random gap after each when idling.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    logic nv;
    char_item_t it;
    if (rst_ni) begin
      nv = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        it.ch = in_if.char_in;
        it.last = in_if.last_in;
        absorb_char(it);
        nv = 1'b0;
        send_gap = idle_on ? $urandom_range(0, 11) : 0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_chars.size() > 0) begin
          it = pending_chars.pop_front();
          in_if.char_in <= it.ch;
          in_if.last_in <= it.last;
          nv = 1'b1;
        end
      end
      in_if.valid <= nv;
    end
  end

  // Receiver: compares each result transfer with the oldest expectation.
  int unsigned recv_stall = 0;
  always @(posedge clk_i) begin
    out_char_t e;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: char %h last %b value %0d", out_if.char_out,
                     out_if.last_out, out_if.signed_value);
        end else begin
          e = expected_chars.pop_front();
          if (out_if.char_out !== e.ch || out_if.last_out !== e.last ||
              out_if.signed_value !== e.value || out_if.overflow !== e.ovf ||
              out_if.bad_digit !== e.bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp char %h last %b val %0d ovf %b bad %b | got %h %b %0d %b %b",
                       e.ch, e.last, e.value, e.ovf, e.bad, out_if.char_out,
                       out_if.last_out, out_if.signed_value, out_if.overflow,
                       out_if.bad_digit);
          end
        end
        recv_stall = idle_on ? $urandom_range(0, 11) : 0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either stream.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Register write: setup phase, then access phase.
  task automatic reg_write(input logic idx, input logic [5:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SRC_BASE) src_reg = val;
    else tgt_reg = val;
  endtask

  task automatic push_char(input logic [7:0] c, input logic l);
    char_item_t it;
    it.ch = c;
    it.last = l;
    pending_chars.push_back(it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Random number string: mostly clean digits of the current base, some noise.
  task automatic push_random_number(input int n);
    int b, d, kind;
    b = eff_base(src_reg);
    if ($urandom_range(0, 2) == 0) push_char(CHAR_MINUS, n == 0);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        push_char(8'($urandom_range(0, 255)), i == n - 1);
      end else if (kind == 1) begin
        push_char(CHAR_MINUS, i == n - 1);
      end else begin
        d = $urandom_range(0, b - 1);
        push_char(to_ascii(6'(d)), i == n - 1);
      end
    end
  endtask

  // Wait until the sender is empty and every result is in, then let the block settle.
  task automatic drain;
    wait (pending_chars.size() == 0 && !in_if.valid && expected_chars.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  logic [5:0] src_set[7] = '{6'd10, 6'd2, 6'd36, 6'd0, 6'd16, 6'd63, 6'd1};
  logic [5:0] tgt_set[7] = '{6'd10, 6'd36, 6'd2, 6'd63, 6'd8, 6'd1, 6'd37};

  initial begin
    int sent;
    in_if.valid = 1'b0;
    in_if.char_in = '0;
    in_if.last_in = 1'b0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero, negative zero, lone minus, misplaced minus, bad bytes,
    // overflow, maximal length output.
    push_str("0");
    push_str("-0");
    push_str("-");
    push_str("12-3");
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h5B, 1'b1);
    push_str("9A");
    push_str("99999999999999999999");
    drain();
    reg_write(REG_SRC_BASE, 6'd36);
    reg_write(REG_TGT_BASE, 6'd2);
    push_str("-ZZZZZZZZZZZZZZ");
    push_str("Z");
    push_str("-1Y2P0IJ32E8E7");
    drain();

    // Random phases across base settings, alternating with and without idling.
    for (int p = 0; p < 7; p++) begin
      idle_on = (p % 2 == 0);
      reg_write(REG_SRC_BASE, src_set[p]);
      reg_write(REG_TGT_BASE, tgt_set[p]);
      sent = 0;
      while (sent < 13) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
        push_random_number(n);
        sent += n + 1;
      end
      drain();
    end

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
